@@ rtl/nsfc_pkg.sv @@
// Shared constants, types and helper functions of the NMEA sentence field checker.
`timescale 1ns / 1ps

package nsfc_pkg;

    // Sizing of the field bookkeeping.
    localparam int MAX_FIELDS = 16;
    localparam int LEN_BITS   = 7;
    localparam int FC_W       = $clog2(MAX_FIELDS + 1);
    localparam int IDX_W      = 4;
    localparam int OLEN_W     = 7;
    localparam int TAG_W      = 48;
    localparam int FCX_W      = (FC_W > IDX_W) ? FC_W : IDX_W;
    localparam int LX_W       = (LEN_BITS > OLEN_W) ? LEN_BITS : OLEN_W;

    localparam logic [LEN_BITS-1:0] LEN_MAX   = '1;
    localparam logic [TAG_W-1:0]    TAG_RESET = 48'h2447_5047_4741;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Checksum digit counter codes.
    localparam logic [1:0] HEX_DIGITS = 2'd2;
    localparam logic [1:0] HEX_DONE   = 2'd3;

    typedef enum logic {
        REC_LENGTH = 1'b0,
        REC_STATUS = 1'b1
    } t_rec_kind;

    // Records that one accepted character asks for.
    typedef struct packed {
        logic                a_valid;
        logic [FC_W-1:0]     a_idx;
        logic [LEN_BITS-1:0] a_len;
        logic                a_last;
        logic                b_valid;
        logic [FC_W-1:0]     b_idx;
        logic [LEN_BITS-1:0] b_len;
        logic                miss_valid;
        logic [FC_W-1:0]     miss_first;
        logic                stat_valid;
    } t_job;

    // Sentence state that the status record reports.
    typedef struct packed {
        logic [FC_W-1:0] field_count;
        logic            header_match;
        logic            star;
        logic [7:0]      xor_sum;
        logic [7:0]      hex_value;
        logic            overflow;
    } t_status;

    // Hex digit decode: bit 4 set when the character is a digit in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: res = {1'b1, 4'(c[3:0] + 4'd9)};
            default:       res = '0;
        endcase
        return res;
    endfunction

    // Field length as shown on the output, saturated.
    function automatic logic [OLEN_W-1:0] len_out(input logic [LEN_BITS-1:0] l);
        logic [LX_W-1:0] e;
        e = LX_W'(l);
        return (e > LX_W'(127)) ? OLEN_W'(127) : e[OLEN_W-1:0];
    endfunction

    // Field index of a length record: low bits only.
    function automatic logic [IDX_W-1:0] idx_out(input logic [FC_W-1:0] f);
        logic [FCX_W-1:0] e;
        e = FCX_W'(f);
        return e[IDX_W-1:0];
    endfunction

    // Field index of the status record, saturated.
    function automatic logic [IDX_W-1:0] idx_sat(input logic [FC_W-1:0] f);
        logic [FCX_W-1:0] e;
        e = FCX_W'(f);
        return (e > FCX_W'(15)) ? IDX_W'(15) : e[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/nsfc_if.sv @@
// Channel interfaces: character input, record output and tag configuration.
`timescale 1ns / 1ps

interface nsfc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface nsfc_rec_if;
    logic       valid;
    logic       ready;
    logic       record_kind;
    logic [3:0] field_index;
    logic [6:0] field_length;
    logic       header_ok;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       star_seen;
    logic       field_overflow;
    logic       last_record;

    modport source (output valid, output record_kind, output field_index,
                    output field_length, output header_ok, output checksum_ok,
                    output computed_sum, output received_sum, output star_seen,
                    output field_overflow, output last_record, input ready);
    modport sink   (input valid, input record_kind, input field_index,
                    input field_length, input header_ok, input checksum_ok,
                    input computed_sum, input received_sum, input star_seen,
                    input field_overflow, input last_record, output ready);
endinterface

interface nsfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] header_tag;

    modport source (output valid, output header_tag, input ready);
    modport sink   (input valid, input header_tag, output ready);
endinterface

@@ rtl/nsfc_parser.sv @@
// Sentence state: checksum, hex digits, field split and header check per character.
`timescale 1ns / 1ps

module nsfc_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic [47:0]           i_tag,
    output nsfc_pkg::t_job        o_job,
    output nsfc_pkg::t_status     o_status
);
    import nsfc_pkg::*;

    logic                r_first;
    logic [7:0]          r_xor;
    logic                r_star;
    logic [1:0]          r_hcnt;
    logic [7:0]          r_hval;
    logic [FC_W-1:0]     r_fc;
    logic [LEN_BITS-1:0] r_len;
    logic [TAG_W-1:0]    r_hs;
    logic                r_ovf;
    logic                r_hm;

    logic [7:0]          b_xor, n_xor;
    logic                b_star, n_star;
    logic [1:0]          b_hcnt, n_hcnt;
    logic [7:0]          b_hval, n_hval;
    logic [FC_W-1:0]     b_fc, n_fc;
    logic [LEN_BITS-1:0] b_len, n_len, cmp_len;
    logic [TAG_W-1:0]    b_hs, n_hs, cmp_hs;
    logic                b_ovf, n_ovf;
    logic                b_hm, n_hm;
    logic                delim;
    logic                hdr_eq;
    logic [4:0]          hexd;

    // A new sentence starts from cleared state.
    always_comb begin
        b_xor  = r_first ? '0 : r_xor;
        b_star = r_first ? 1'b0 : r_star;
        b_hcnt = r_first ? '0 : r_hcnt;
        b_hval = r_first ? '0 : r_hval;
        b_fc   = r_first ? '0 : r_fc;
        b_len  = r_first ? '0 : r_len;
        b_hs   = r_first ? '0 : r_hs;
        b_ovf  = r_first ? 1'b0 : r_ovf;
        b_hm   = r_first ? 1'b0 : r_hm;
    end

    // Checksum, asterisk and received digits; the first character is plain data.
    always_comb begin
        n_xor  = b_xor;
        n_star = b_star;
        n_hcnt = b_hcnt;
        n_hval = b_hval;
        delim  = 1'b0;
        hexd   = hex_digit(i_char);
        if (!r_first) begin
            if (!b_star) begin
                if (i_char == CH_STAR) begin
                    n_star = 1'b1;
                    delim  = 1'b1;
                end else begin
                    n_xor = b_xor ^ i_char;
                    delim = (i_char == CH_COMMA);
                end
            end else begin
                if (b_hcnt < HEX_DIGITS) begin
                    if (hexd[4]) begin
                        n_hval = {b_hval[3:0], hexd[3:0]};
                        n_hcnt = b_hcnt + 2'd1;
                    end else begin
                        n_hcnt = HEX_DONE;
                    end
                end else begin
                    n_hcnt = HEX_DONE;
                end
                delim = (i_char == CH_COMMA) || (i_char == CH_STAR);
            end
        end
    end

    // Field split, length count and header capture.
    always_comb begin
        n_fc  = b_fc;
        n_len = b_len;
        n_hs  = b_hs;
        n_ovf = b_ovf;
        if (delim) begin
            if (b_fc < FC_W'(MAX_FIELDS)) begin
                n_fc = b_fc + FC_W'(1);
            end
            if (n_fc >= FC_W'(MAX_FIELDS)) begin
                n_ovf = 1'b1;
            end
            n_len = '0;
        end else begin
            if (b_len != LEN_MAX) begin
                n_len = b_len + LEN_BITS'(1);
            end
            if (b_fc == '0) begin
                n_hs = {b_hs[TAG_W-9:0], i_char};
            end
        end
    end

    // Header check: field zero closes either at a delimiter or at the end.
    always_comb begin
        cmp_len = delim ? b_len : n_len;
        cmp_hs  = delim ? b_hs : n_hs;
        hdr_eq  = (cmp_len == LEN_BITS'(6)) && (cmp_hs == i_tag) &&
                  (cmp_hs[TAG_W-1:TAG_W-8] != CH_COMMA);
        n_hm    = b_hm;
        if (delim && (b_fc == '0)) begin
            n_hm = hdr_eq;
        end
        if (i_last && (n_fc == '0)) begin
            n_hm = hdr_eq;
        end
    end

    // Records caused by this character.
    always_comb begin
        o_job.a_valid    = delim && (b_fc < FC_W'(MAX_FIELDS));
        o_job.a_idx      = b_fc;
        o_job.a_len      = b_len;
        o_job.a_last     = !i_last;
        o_job.b_valid    = i_last && (n_fc < FC_W'(MAX_FIELDS));
        o_job.b_idx      = n_fc;
        o_job.b_len      = n_len;
        o_job.miss_valid = i_last && !n_star && (n_fc < FC_W'(MAX_FIELDS - 1));
        o_job.miss_first = n_fc + FC_W'(1);
        o_job.stat_valid = i_last;
    end

    // Stored sentence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_xor   <= '0;
            r_star  <= 1'b0;
            r_hcnt  <= '0;
            r_hval  <= '0;
            r_fc    <= '0;
            r_len   <= '0;
            r_hs    <= '0;
            r_ovf   <= 1'b0;
            r_hm    <= 1'b0;
        end else if (i_accept) begin
            r_first <= i_last;
            r_xor   <= n_xor;
            r_star  <= n_star;
            r_hcnt  <= n_hcnt;
            r_hval  <= n_hval;
            r_fc    <= n_fc;
            r_len   <= n_len;
            r_hs    <= n_hs;
            r_ovf   <= n_ovf;
            r_hm    <= n_hm;
        end
    end

    assign o_status.field_count  = r_fc;
    assign o_status.header_match = r_hm;
    assign o_status.star         = r_star;
    assign o_status.xor_sum      = r_xor;
    assign o_status.hex_value    = r_hval;
    assign o_status.overflow     = r_ovf;

endmodule

@@ rtl/nsfc_emitter.sv @@
// Record register: holds a character's records, sends one beat a cycle while ready is high.
`timescale 1ns / 1ps

module nsfc_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nsfc_pkg::t_job     i_job,
    input  nsfc_pkg::t_status  i_status,
    output logic               o_can_load,
    nsfc_rec_if.source         o_rec_if
);
    import nsfc_pkg::*;

    logic                r_a_pend;
    logic [FC_W-1:0]     r_a_idx;
    logic [LEN_BITS-1:0] r_a_len;
    logic                r_a_last;
    logic                r_b_pend;
    logic [FC_W-1:0]     r_b_idx;
    logic [LEN_BITS-1:0] r_b_len;
    logic                r_m_pend;
    logic [FC_W-1:0]     r_m_idx;
    logic                r_s_pend;

    logic                busy;
    logic                fire;
    logic                last_beat;
    logic                m_end;

    assign busy      = r_a_pend || r_b_pend || r_m_pend || r_s_pend;
    assign fire      = busy && o_rec_if.ready;
    assign last_beat = (r_a_pend && !r_b_pend && !r_m_pend && !r_s_pend) ||
                       (r_s_pend && !r_a_pend && !r_b_pend && !r_m_pend);
    assign m_end     = (r_m_idx == FC_W'(MAX_FIELDS - 1));
    assign o_can_load = !busy || (fire && last_beat);

    // Payload of the beat at the head: delimiter record, final field, missing fields, status.
    always_comb begin
        o_rec_if.valid          = busy;
        o_rec_if.record_kind    = REC_LENGTH;
        o_rec_if.field_index    = '0;
        o_rec_if.field_length   = '0;
        o_rec_if.header_ok      = 1'b0;
        o_rec_if.checksum_ok    = 1'b0;
        o_rec_if.computed_sum   = '0;
        o_rec_if.received_sum   = '0;
        o_rec_if.star_seen      = 1'b0;
        o_rec_if.field_overflow = 1'b0;
        o_rec_if.last_record    = 1'b0;
        if (r_a_pend) begin
            o_rec_if.field_index  = idx_out(r_a_idx);
            o_rec_if.field_length = len_out(r_a_len);
            o_rec_if.last_record  = r_a_last;
        end else if (r_b_pend) begin
            o_rec_if.field_index  = idx_out(r_b_idx);
            o_rec_if.field_length = len_out(r_b_len);
        end else if (r_m_pend) begin
            o_rec_if.field_index  = idx_out(r_m_idx);
        end else if (r_s_pend) begin
            o_rec_if.record_kind    = REC_STATUS;
            o_rec_if.field_index    = idx_sat(i_status.field_count);
            o_rec_if.header_ok      = i_status.header_match;
            o_rec_if.checksum_ok    = i_status.star &&
                                      (i_status.hex_value == i_status.xor_sum);
            o_rec_if.computed_sum   = i_status.xor_sum;
            o_rec_if.received_sum   = i_status.hex_value;
            o_rec_if.star_seen      = i_status.star;
            o_rec_if.field_overflow = i_status.overflow;
            o_rec_if.last_record    = 1'b1;
        end
    end

    // Retire the head beat, or take the records of a new character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_pend <= 1'b0;
            r_b_pend <= 1'b0;
            r_m_pend <= 1'b0;
            r_s_pend <= 1'b0;
        end else if (i_load) begin
            r_a_pend <= i_job.a_valid;
            r_b_pend <= i_job.b_valid;
            r_m_pend <= i_job.miss_valid;
            r_s_pend <= i_job.stat_valid;
        end else if (fire) begin
            if (r_a_pend) begin
                r_a_pend <= 1'b0;
            end else if (r_b_pend) begin
                r_b_pend <= 1'b0;
            end else if (r_m_pend) begin
                if (m_end) begin
                    r_m_pend <= 1'b0;
                end
            end else begin
                r_s_pend <= 1'b0;
            end
        end
    end

    // Record payload and missing-field index.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_idx  <= i_job.a_idx;
            r_a_len  <= i_job.a_len;
            r_a_last <= i_job.a_last;
            r_b_idx  <= i_job.b_idx;
            r_b_len  <= i_job.b_len;
            r_m_idx  <= i_job.miss_first;
        end else if (fire && !r_a_pend && !r_b_pend && r_m_pend && !m_end) begin
            r_m_idx  <= r_m_idx + FC_W'(1);
        end
    end

endmodule

@@ rtl/nmea_sentence_field_checker.sv @@
// Latency: the first record of a character is offered in the cycle after its beat.
// Throughput: one character per cycle while the output is ready and each character
// gives at most one record. A final character gives up to MAX_FIELDS + 1 records,
// one per cycle while ready is high; the input is held off until the last is taken.
// Reset (synchronous, active low) clears all sentence state and pending records and
// loads the header tag with "$GPGGA".
`timescale 1ns / 1ps

module nmea_sentence_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsfc_char_if.sink   i_char_if,
    nsfc_cfg_if.sink    i_cfg_if,
    nsfc_rec_if.source  o_rec_if
);
    import nsfc_pkg::*;

    logic [TAG_W-1:0] r_header_tag;
    logic             can_load;
    logic             accept;
    t_job             job;
    t_status          status;

    // Header tag register; writes are always taken.
    assign i_cfg_if.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_tag <= TAG_RESET;
        end else if (i_cfg_if.valid) begin
            r_header_tag <= i_cfg_if.header_tag;
        end
    end

    // A character beat is taken whenever the record register can take its records.
    assign i_char_if.ready = can_load;
    assign accept          = i_char_if.valid && can_load;

    nsfc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_char_if.char_in),
        .i_last   (i_char_if.last_char),
        .i_tag    (r_header_tag),
        .o_job    (job),
        .o_status (status)
    );

    nsfc_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_job      (job),
        .i_status   (status),
        .o_can_load (can_load),
        .o_rec_if   (o_rec_if)
    );

endmodule

@@ rtl/nsfc_checker.sv @@
// Port-level checks of the NMEA sentence field checker, bound to the top level.
`timescale 1ns / 1ps

module nsfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_record_kind,
    input logic [3:0] i_field_index,
    input logic [6:0] i_field_length,
    input logic       i_header_ok,
    input logic       i_checksum_ok,
    input logic [7:0] i_computed_sum,
    input logic [7:0] i_received_sum,
    input logic       i_star_seen,
    input logic       i_field_overflow,
    input logic       i_last_record
);
    import nsfc_pkg::*;

    // A stalled record beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_field_index) && $stable(i_field_length) &&
             $stable(i_record_kind) && $stable(i_last_record)))
        else $error("record beat changed while stalled");

    // The status record always closes the records of its character.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_record_kind == REC_STATUS)) |-> i_last_record)
        else $error("status record without last_record");

    // Length records carry no status information.
    a_length_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_record_kind == REC_LENGTH)) |->
            (!i_header_ok && !i_checksum_ok && !i_star_seen && !i_field_overflow &&
             (i_computed_sum == 8'd0) && (i_received_sum == 8'd0)))
        else $error("length record carries status fields");

    // A good checksum needs an asterisk and equal sums; status records have no length.
    a_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_checksum_ok) |->
            (i_star_seen && (i_computed_sum == i_received_sum) && (i_field_length == 7'd0)))
        else $error("checksum_ok inconsistent with sums");

endmodule

bind nmea_sentence_field_checker nsfc_checker u_nsfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_rec_if.valid),
    .i_out_ready      (o_rec_if.ready),
    .i_record_kind    (o_rec_if.record_kind),
    .i_field_index    (o_rec_if.field_index),
    .i_field_length   (o_rec_if.field_length),
    .i_header_ok      (o_rec_if.header_ok),
    .i_checksum_ok    (o_rec_if.checksum_ok),
    .i_computed_sum   (o_rec_if.computed_sum),
    .i_received_sum   (o_rec_if.received_sum),
    .i_star_seen      (o_rec_if.star_seen),
    .i_field_overflow (o_rec_if.field_overflow),
    .i_last_record    (o_rec_if.last_record)
);
